>>> sv/timed_flight_phase_sequencer_defines.svh
// Assertion macros shared by the flight phase sequencer modules.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef TIMED_FLIGHT_PHASE_SEQUENCER_DEFINES_SVH
`define TIMED_FLIGHT_PHASE_SEQUENCER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TFPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that, when seen, implies another one at the next edge.
`define TFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tfps_pkg.sv
// Package for the timed flight phase sequencer: beat layouts, register
// indexes, phase codes, reset values and the phase duration table. No dependencies.
`default_nettype none

package tfps_pkg;

  // Width of the time base; elapsed time wraps at this width.
  localparam int unsigned TimeBits = 32;
  // Width used to compare elapsed time against a duration.
  localparam int unsigned CmpBits  = (TimeBits > 32) ? TimeBits : 32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgSpeedCap   = 2'd0,
    CfgBurpLevel  = 2'd1,
    CfgFlySpeed   = 2'd2,
    CfgFlyDurMs   = 2'd3
  } cfg_idx_e;

  // Register reset values.
  localparam logic [7:0]  SpeedCapRst  = 8'd180;
  localparam logic [7:0]  BurpLevelRst = 8'd90;
  localparam logic [7:0]  FlySpeedRst  = 8'd120;
  localparam logic [31:0] FlyDurMsRst  = 32'd600000;

  // Phase codes.
  localparam logic [2:0] PhaseWait    = 3'd0;
  localparam logic [2:0] PhaseArmed   = 3'd1;
  localparam logic [2:0] PhaseRamp    = 3'd2;
  localparam logic [2:0] PhaseTakeoff = 3'd3;
  localparam logic [2:0] PhaseFly     = 3'd4;
  localparam logic [2:0] PhaseBurp    = 3'd5;
  localparam logic [2:0] PhaseReady   = 3'd6;
  localparam logic [2:0] PhaseLand    = 3'd7;

  // Fixed throttle level held in the wait phase.
  localparam logic [7:0] WaitLevel = 8'd25;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [31:0] fly_duration_ms;
    logic [7:0]  fly_speed;
    logic [7:0]  burp_level;
    logic [7:0]  speed_cap;
  } cfg_t;

  // Input tdata layout, lowest field last.
  typedef struct packed {
    logic [8:0]  boost;
    logic [8:0]  trim;
    logic        yaw_low;
    logic        yaw_excess;
    logic        pitch_excess;
    logic [2:0]  new_phase;
    logic [31:0] now_ms;
  } in_data_t;

  // Output tdata layout, lowest field last.
  typedef struct packed {
    logic [2:0] pad;
    logic       stop_request;
    logic       advanced;
    logic [7:0] throttle_out;
    logic [2:0] phase_out;
  } out_data_t;

  // Duration of each phase in milliseconds.
  function automatic logic [CmpBits-1:0] phase_dur(input logic [2:0]  ph,
                                                   input logic [31:0] fly_ms);
    logic [CmpBits-1:0] d;
    unique case (ph)
      PhaseWait:    d = CmpBits'(1000);
      PhaseArmed:   d = CmpBits'(3000);
      PhaseRamp:    d = CmpBits'(5000);
      PhaseTakeoff: d = CmpBits'(5000);
      PhaseFly:     d = CmpBits'(fly_ms);
      PhaseBurp:    d = CmpBits'(500);
      PhaseReady:   d = CmpBits'(2000);
      PhaseLand:    d = CmpBits'(3000);
      default:      d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> sv/tfps_cfg_regs.sv
// Configuration registers of the flight phase sequencer.
// Uses tfps_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module tfps_cfg_regs (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_wdata_i,
  output tfps_pkg::cfg_t            cfg_o
);

  tfps_pkg::cfg_t cfg_q, cfg_d;

  // Write decode: one register per index.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tfps_pkg::cfg_idx_e'(cfg_idx_i))
        tfps_pkg::CfgSpeedCap:  cfg_d.speed_cap       = cfg_wdata_i[7:0];
        tfps_pkg::CfgBurpLevel: cfg_d.burp_level      = cfg_wdata_i[7:0];
        tfps_pkg::CfgFlySpeed:  cfg_d.fly_speed       = cfg_wdata_i[7:0];
        tfps_pkg::CfgFlyDurMs:  cfg_d.fly_duration_ms = cfg_wdata_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_cap       <= tfps_pkg::SpeedCapRst;
      cfg_q.burp_level      <= tfps_pkg::BurpLevelRst;
      cfg_q.fly_speed       <= tfps_pkg::FlySpeedRst;
      cfg_q.fly_duration_ms <= tfps_pkg::FlyDurMsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/tfps_core.sv
// Phase state, phase timer and throttle level of the flight phase sequencer,
// with the single-pass logic that turns one item into one result. Uses tfps_pkg.
`default_nettype none

`include "timed_flight_phase_sequencer_defines.svh"

module tfps_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire logic                 action_i,
  input  wire tfps_pkg::in_data_t   data_i,
  input  wire tfps_pkg::cfg_t       cfg_i,
  output tfps_pkg::out_data_t       res_o
);

  logic [2:0]                   phase_q, phase_d;
  logic [tfps_pkg::TimeBits-1:0] start_q, start_d;
  logic [7:0]                   level_q, level_d;

  logic [tfps_pkg::TimeBits-1:0] now_t;
  logic [tfps_pkg::TimeBits-1:0] elapsed;
  logic                          timeout;
  logic [2:0]                    tick_phase;
  logic [8:0]                    ramp_sum;
  logic [7:0]                    ramp_level;
  logic [7:0]                    tick_level;
  logic                          tick_stop;
  logic                          fault_any;
  logic signed [10:0]            adj;
  logic [7:0]                    thr;

  // Timeout check on the wrapped elapsed time.
  assign now_t   = tfps_pkg::TimeBits'(data_i.now_ms);
  assign elapsed = now_t - start_q;
  assign timeout = tfps_pkg::CmpBits'(elapsed) > tfps_pkg::phase_dur(phase_q,
                                                   cfg_i.fly_duration_ms);
  assign tick_phase = timeout ? phase_q + 3'd1 : phase_q;

  // Ramp step saturates at the ceiling.
  assign ramp_sum   = {1'b0, level_q} + 9'd1;
  assign ramp_level = (ramp_sum > {1'b0, cfg_i.speed_cap}) ? cfg_i.speed_cap
                                                           : ramp_sum[7:0];
  assign fault_any  = data_i.pitch_excess | data_i.yaw_excess;

  // Throttle level for the phase reached by a tick.
  always_comb begin
    tick_level = '0;
    tick_stop  = 1'b0;
    unique case (tick_phase)
      tfps_pkg::PhaseWait:  tick_level = tfps_pkg::WaitLevel;
      tfps_pkg::PhaseArmed: tick_level = '0;
      tfps_pkg::PhaseRamp:  tick_level = ramp_level;
      tfps_pkg::PhaseTakeoff: begin
        tick_level = fault_any ? 8'd0 : cfg_i.speed_cap;
        tick_stop  = fault_any;
      end
      tfps_pkg::PhaseFly: begin
        tick_level = (fault_any | data_i.yaw_low) ? 8'd0 : cfg_i.fly_speed;
        tick_stop  = fault_any | data_i.yaw_low;
      end
      tfps_pkg::PhaseBurp:  tick_level = cfg_i.burp_level;
      tfps_pkg::PhaseReady: tick_level = cfg_i.fly_speed;
      tfps_pkg::PhaseLand: begin
        tick_level = '0;
        tick_stop  = 1'b1;
      end
      default: begin
        tick_level = '0;
        tick_stop  = 1'b0;
      end
    endcase
  end

  // Next state: a force loads the phase and restarts the timer, a tick may advance.
  always_comb begin
    if (action_i) begin
      phase_d = data_i.new_phase;
      start_d = now_t;
      level_d = level_q;
    end else begin
      phase_d = tick_phase;
      start_d = timeout ? now_t : start_q;
      level_d = tick_level;
    end
  end

  // Motor command: level plus trim plus boost, clamped to 0..speed_cap.
  assign adj = $signed({3'b000, level_d})
             + $signed({{2{data_i.trim[8]}}, data_i.trim})
             + $signed({{2{data_i.boost[8]}}, data_i.boost});

  always_comb begin
    if (adj[10]) begin
      thr = '0;
    end else if (adj[9:0] > {2'b00, cfg_i.speed_cap}) begin
      thr = cfg_i.speed_cap;
    end else begin
      thr = adj[7:0];
    end
  end

  assign res_o.pad          = '0;
  assign res_o.stop_request = ~action_i & tick_stop;
  assign res_o.advanced     = ~action_i & timeout;
  assign res_o.throttle_out = thr;
  assign res_o.phase_out    = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tfps_pkg::PhaseWait;
      start_q <= '0;
      level_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      start_q <= start_d;
      level_q <= level_d;
    end
  end

  // A stop request always leaves the throttle level at zero.
  `TFPS_ASSERT_NEXT(a_stop_zero_level, fire_i && res_o.stop_request, level_q == 8'd0,
                    "stop request left a non-zero throttle level")
  // An advance restarts the phase timer at the item's time.
  `TFPS_ASSERT_NEXT(a_adv_restart, fire_i && res_o.advanced,
                    start_q == $past(now_t), "advance did not restart the phase timer")
  // The command of an item moving on never exceeds the ceiling.
  `TFPS_ASSERT(a_thr_ceiling, !fire_i || (res_o.throttle_out <= cfg_i.speed_cap),
               "throttle command above ceiling")

endmodule

`default_nettype wire

>>> sv/timed_flight_phase_sequencer.sv
// Timed flight phase sequencer: each input beat is a time tick or a forced
// phase and yields one result beat with phase, throttle command and flags. The
// block takes one beat per clock while the output side keeps taking results: a
// beat lands in an input register, then passes the phase/throttle logic into an
// output register once that register can load, and the result is offered from
// the output register until the output side takes it. The input side keeps
// accepting while a result waits, as long as the input register is free or
// moving on. Configuration writes take effect at once.
// Uses tfps_pkg, tfps_cfg_regs and tfps_core.
`default_nettype none

`include "timed_flight_phase_sequencer_defines.svh"

module timed_flight_phase_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  // Input stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // now_ms[31:0], new_phase[34:32], pitch_excess[35], yaw_excess[36],
  // yaw_low[37], trim[46:38], boost[55:47]
  input  wire logic [55:0] s_axis_tdata_i,
  // action[0]: 0 time tick, 1 force phase
  input  wire logic        s_axis_tuser_i,
  // Result stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // phase_out[2:0], throttle_out[10:3], advanced[11], stop_request[12], zeros[15:13]
  output logic [15:0]      m_axis_tdata_o
);

  tfps_pkg::cfg_t      cfg;
  tfps_pkg::in_data_t  in_q;
  logic                in_act_q;
  logic                in_valid_q;
  tfps_pkg::out_data_t res;
  tfps_pkg::out_data_t out_q;
  logic                out_valid_q;
  logic                out_free;
  logic                fire;
  logic                s_beat;

  tfps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: the input register moves on whenever the output register can load.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || fire;
  assign s_beat          = s_axis_tvalid_i && s_axis_tready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_beat) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_q     <= tfps_pkg::in_data_t'(s_axis_tdata_i);
      in_act_q <= s_axis_tuser_i;
    end
  end

  tfps_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .action_i (in_act_q),
    .data_i   (in_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // Input side only stalls when both registers are full and the output is held.
  `TFPS_ASSERT(a_stall_full, !s_axis_tready_o |-> (in_valid_q && out_valid_q &&
               !m_axis_tready_i), "input stalled with room in the pipeline")
  // A held item moves on as soon as the output register is empty.
  `TFPS_ASSERT_NEXT(a_move_on, in_valid_q && !out_valid_q, out_valid_q,
                    "item did not reach the output register")
  // A taken result with nothing behind it empties the output register.
  `TFPS_ASSERT_NEXT(a_drain, out_valid_q && m_axis_tready_i && !fire, !out_valid_q,
                    "result shown twice")

endmodule

`default_nettype wire

>>> test/timed_flight_phase_sequencer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the timed flight phase sequencer. It follows register writes and input
// beats, predicts each result beat and compares it with the result beat the block sends.
// Depends on tfps_pkg for the beat layouts, phase codes, register indexes and reset values.
module timed_flight_phase_sequencer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  // now_ms, new_phase, pitch_excess, yaw_excess, yaw_low, trim, boost
  input  logic [55:0] in_data_i,
  // High for a forced phase, low for a time tick.
  input  logic        in_force_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  // phase_out, throttle_out, advanced, stop_request, zero fill
  input  logic [15:0] res_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Register copies.
  logic [7:0]  speed_cap_q;
  logic [7:0]  burp_level_q;
  logic [7:0]  fly_speed_q;
  logic [31:0] fly_ms_q;

  // Sequencer state as the block should hold it.
  logic [2:0]  phase_q;
  logic [31:0] phase_start_q;
  logic [7:0]  level_q;

  // Throttle commands predicted but not yet seen, oldest first.
  tfps_pkg::out_data_t predicted_commands[$];
  int                  results_seen;

  // Apply one beat to the state and return the command the block should send.
  function automatic tfps_pkg::out_data_t advance_flight(input tfps_pkg::in_data_t beat,
                                                         input logic force_phase);
    tfps_pkg::out_data_t cmd;
    logic [31:0] elapsed;
    logic [31:0] span;
    logic [8:0]  ramp_next;
    int          level_sum;
    cmd = '0;
    if (force_phase) begin
      // A forced phase restarts the timer and keeps the throttle level.
      phase_q       = beat.new_phase;
      phase_start_q = beat.now_ms;
    end else begin
      elapsed = beat.now_ms - phase_start_q;
      case (phase_q)
        tfps_pkg::PhaseWait:    span = 32'd1000;
        tfps_pkg::PhaseArmed:   span = 32'd3000;
        tfps_pkg::PhaseRamp:    span = 32'd5000;
        tfps_pkg::PhaseTakeoff: span = 32'd5000;
        tfps_pkg::PhaseFly:     span = fly_ms_q;
        tfps_pkg::PhaseBurp:    span = 32'd500;
        tfps_pkg::PhaseReady:   span = 32'd2000;
        default:                span = 32'd3000;
      endcase
      if (elapsed > span) begin
        phase_q       = phase_q + 3'd1;
        phase_start_q = beat.now_ms;
        cmd.advanced  = 1'b1;
      end
      // Throttle level for the phase now in force.
      case (phase_q)
        tfps_pkg::PhaseWait:  level_q = tfps_pkg::WaitLevel;
        tfps_pkg::PhaseArmed: level_q = 8'd0;
        tfps_pkg::PhaseRamp: begin
          ramp_next = {1'b0, level_q} + 9'd1;
          level_q   = (ramp_next > {1'b0, speed_cap_q}) ? speed_cap_q : ramp_next[7:0];
        end
        tfps_pkg::PhaseTakeoff: begin
          if (beat.pitch_excess || beat.yaw_excess) begin
            level_q          = 8'd0;
            cmd.stop_request = 1'b1;
          end else begin
            level_q = speed_cap_q;
          end
        end
        tfps_pkg::PhaseFly: begin
          if (beat.pitch_excess || beat.yaw_excess || beat.yaw_low) begin
            level_q          = 8'd0;
            cmd.stop_request = 1'b1;
          end else begin
            level_q = fly_speed_q;
          end
        end
        tfps_pkg::PhaseBurp:  level_q = burp_level_q;
        tfps_pkg::PhaseReady: level_q = fly_speed_q;
        default: begin
          level_q          = 8'd0;
          cmd.stop_request = 1'b1;
        end
      endcase
    end
    // Motor command: level plus trim plus boost, held within 0 to the ceiling.
    level_sum = int'(level_q) + int'($signed(beat.trim)) + int'($signed(beat.boost));
    if (level_sum < 0) level_sum = 0;
    if (level_sum > int'(speed_cap_q)) level_sum = int'(speed_cap_q);
    cmd.throttle_out = level_sum[7:0];
    cmd.phase_out    = phase_q;
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    tfps_pkg::out_data_t got;
    tfps_pkg::out_data_t want;
    if (!rst_ni) begin
      speed_cap_q   <= tfps_pkg::SpeedCapRst;
      burp_level_q  <= tfps_pkg::BurpLevelRst;
      fly_speed_q   <= tfps_pkg::FlySpeedRst;
      fly_ms_q      <= tfps_pkg::FlyDurMsRst;
      phase_q       <= tfps_pkg::PhaseWait;
      phase_start_q <= '0;
      level_q       <= '0;
      predicted_commands.delete();
      results_seen  = 0;
      fail_count_o  = 0;
      pending_o     <= 0;
    end else begin
      // Registers are only written while nothing is in flight.
      if (cfg_we_i) begin
        case (tfps_pkg::cfg_idx_e'(cfg_idx_i))
          tfps_pkg::CfgSpeedCap:  speed_cap_q  = cfg_wdata_i[7:0];
          tfps_pkg::CfgBurpLevel: burp_level_q = cfg_wdata_i[7:0];
          tfps_pkg::CfgFlySpeed:  fly_speed_q  = cfg_wdata_i[7:0];
          default:                fly_ms_q     = cfg_wdata_i;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        predicted_commands.push_back(advance_flight(tfps_pkg::in_data_t'(in_data_i),
                                                    in_force_i));
      end

      if (res_valid_i && res_ready_i) begin
        got = tfps_pkg::out_data_t'(res_data_i);
        results_seen++;
        if (predicted_commands.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("Result beat %0d (tdata %h) arrived with nothing predicted",
                     results_seen, res_data_i);
          end
        end else begin
          want = predicted_commands.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("Result beat %0d: expected phase %0d throttle %0d advanced %0b stop %0b",
                       results_seen, want.phase_out, want.throttle_out, want.advanced,
                       want.stop_request);
              $display("  got phase %0d throttle %0d advanced %0b stop %0b fill %b",
                       got.phase_out, got.throttle_out, got.advanced, got.stop_request,
                       got.pad);
            end
          end
        end
      end

      pending_o <= predicted_commands.size();
    end
  end

endmodule

>>> test/timed_flight_phase_sequencer_test.sv
`timescale 1ns / 1ps
// Top of the flight phase sequencer testbench: clock, reset, register writes and beat
// stimulus with random gaps and stalls. Depends on tfps_pkg, the block and its checker.
module timed_flight_phase_sequencer_test;

  // Meaning of the tuser bit on the input stream.
  localparam logic ActTick  = 1'b0;
  localparam logic ActForce = 1'b1;

  // Cycles allowed for the last beat to leave the block.
  localparam int DrainCycles = 8;
  // Length of the long output stall.
  localparam int HoldCycles  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  int          fail_count;
  int          commands_due;
  int          send_idle_pct = 33;
  int          recv_idle_pct = 83;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [31:0] clock_ms;

  always #5 clk_i = ~clk_i;

  timed_flight_phase_sequencer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  timed_flight_phase_sequencer_checker i_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_i   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .in_force_i   (s_axis_tuser_i),
    .res_valid_i  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_data_i   (m_axis_tdata_o),
    .fail_count_o (fail_count),
    .pending_o    (commands_due)
  );

  // Output side: random stalls, plus one long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen       <= hold_req;
      hold_left       <= HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one beat after a random gap and wait until it is taken.
  task automatic send_item(input logic act, input logic [31:0] now, input logic [2:0] ph,
                           input logic pex, input logic yex, input logic ylo,
                           input int trim_v, input int boost_v);
    tfps_pkg::in_data_t beat;
    beat.now_ms       = now;
    beat.new_phase    = ph;
    beat.pitch_excess = pex;
    beat.yaw_excess   = yex;
    beat.yaw_low      = ylo;
    beat.trim         = 9'(trim_v);
    beat.boost        = 9'(boost_v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= beat;
    s_axis_tuser_i  <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted command has come back.
  task automatic wait_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (commands_due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all four registers; only called while the block is idle.
  task automatic apply_settings(input logic [7:0] ceiling, input logic [7:0] burp,
                                input logic [7:0] cruise, input logic [31:0] fly_ms);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= tfps_pkg::CfgSpeedCap;
    cfg_wdata_i <= 32'(ceiling);
    @(posedge clk_i);
    cfg_idx_i   <= tfps_pkg::CfgBurpLevel;
    cfg_wdata_i <= 32'(burp);
    @(posedge clk_i);
    cfg_idx_i   <= tfps_pkg::CfgFlySpeed;
    cfg_wdata_i <= 32'(cruise);
    @(posedge clk_i);
    cfg_idx_i   <= tfps_pkg::CfgFlyDurMs;
    cfg_wdata_i <= fly_ms;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Trim or boost: often zero so the bare level shows, otherwise anywhere from -180 to 180.
  function automatic int pick_adjust();
    if ($urandom_range(99) < 30) return 0;
    return int'($urandom_range(360)) - 180;
  endfunction

  // Mostly a steady flow of ticks with rising time, some forced phases, some noise.
  task automatic send_random_item();
    int          pick;
    logic [31:0] step;
    pick = $urandom_range(99);
    if (pick < 8) begin
      clock_ms = clock_ms + $urandom_range(50);
      send_item(ActForce, clock_ms, 3'($urandom_range(7)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'($urandom_range(1)), pick_adjust(), pick_adjust());
    end else if (pick < 12) begin
      clock_ms = $urandom;
      send_item(1'($urandom_range(1)), clock_ms, 3'($urandom_range(7)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'($urandom_range(1)), pick_adjust(), pick_adjust());
    end else begin
      step     = ($urandom_range(9) == 0) ? $urandom_range(6000) : $urandom_range(900);
      clock_ms = clock_ms + step;
      send_item(ActTick, clock_ms, 3'($urandom_range(7)), ($urandom_range(99) < 4),
                ($urandom_range(99) < 4), ($urandom_range(99) < 4), pick_adjust(),
                pick_adjust());
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= tfps_pkg::CfgSpeedCap;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= ActTick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the phases by hand with the reset settings.
    send_item(ActTick,  32'd0,    tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b0,    0,    0);
    // Elapsed equal to the duration does not advance; one more millisecond does.
    send_item(ActTick,  32'd1000, tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActTick,  32'd1001, tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b0,    0,    0);
    // Into the ramp; largest trim and boost clamp high, smallest clamp to zero.
    send_item(ActTick,  32'd4002, tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b0,  180,  180);
    send_item(ActTick,  32'd4003, tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b0, -180, -180);
    // Takeoff faults, then a clean takeoff tick.
    send_item(ActForce, 32'd5000, tfps_pkg::PhaseTakeoff, 1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActTick,  32'd5001, tfps_pkg::PhaseWait,    1'b1, 1'b0, 1'b0,    0,    0);
    send_item(ActTick,  32'd5002, tfps_pkg::PhaseWait,    1'b0, 1'b1, 1'b0,    0,    0);
    send_item(ActTick,  32'd5003, tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b0,    0,    0);
    // Fly: low yaw stops the run, a clean tick gives the cruise level.
    send_item(ActForce, 32'd6000, tfps_pkg::PhaseFly,     1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActTick,  32'd6001, tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b1,    0,    0);
    send_item(ActTick,  32'd6002, tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b0,  -20,    5);
    // A forced phase reports the kept level.
    send_item(ActForce, 32'd7000, tfps_pkg::PhaseBurp,    1'b1, 1'b1, 1'b1,    1,    0);
    send_item(ActTick,  32'd7001, tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActForce, 32'd8000, tfps_pkg::PhaseReady,   1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActTick,  32'd8001, tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActForce, 32'd9000, tfps_pkg::PhaseLand,    1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActTick,  32'd9001, tfps_pkg::PhaseWait,    1'b0, 1'b0, 1'b0,    0,    0);
    // Landing times out and the sequence wraps back to wait.
    send_item(ActTick,  32'd12002, tfps_pkg::PhaseWait,   1'b0, 1'b0, 1'b0,    0,    0);
    // Elapsed time across the wrap of the millisecond counter.
    send_item(ActForce, 32'hFFFF_FF00, tfps_pkg::PhaseWait, 1'b0, 1'b0, 1'b0, -1,   0);
    send_item(ActTick,  32'h0000_0300, tfps_pkg::PhaseWait, 1'b0, 1'b0, 1'b0,  0,   0);
    send_item(ActForce, 32'd0,     tfps_pkg::PhaseArmed,  1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActForce, 32'd20000, tfps_pkg::PhaseBurp,   1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActTick,  32'd20001, tfps_pkg::PhaseWait,   1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActForce, 32'd20002, tfps_pkg::PhaseRamp,   1'b0, 1'b0, 1'b0,    0,    0);
    wait_results();

    // Ceiling lowered under the held level; levels above the ceiling; zero fly time.
    apply_settings(8'd40, 8'd255, 8'd255, 32'd0);
    send_item(ActTick,  32'd20003, tfps_pkg::PhaseWait,   1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActForce, 32'd20004, tfps_pkg::PhaseFly,    1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActTick,  32'd20004, tfps_pkg::PhaseWait,   1'b0, 1'b0, 1'b0,    0,    0);
    send_item(ActTick,  32'd20005, tfps_pkg::PhaseWait,   1'b0, 1'b0, 1'b0,    0,    0);

    // Random flight sequences under several settings and three idling patterns.
    clock_ms = $urandom;
    for (int blk = 0; blk < 9; blk++) begin
      if (blk == 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 33;
      end
      if (blk == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_results();
      case (blk)
        0: apply_settings(8'd180, 8'd90, 8'd120, 32'd2000);
        1: apply_settings(8'd0, 8'd0, 8'd0, 32'd0);
        2: apply_settings(8'd180, 8'd180, 8'd180, 32'd1500);
        3: apply_settings(8'd12, 8'd180, 8'd7, 32'hFFFF_FFFF);
        4: apply_settings(tfps_pkg::SpeedCapRst, tfps_pkg::BurpLevelRst,
                          tfps_pkg::FlySpeedRst, tfps_pkg::FlyDurMsRst);
        8: apply_settings(8'($urandom_range(180)), 8'($urandom_range(180)),
                          8'($urandom_range(180)), $urandom);
        default: apply_settings(8'($urandom_range(180)), 8'($urandom_range(180)),
                                8'($urandom_range(180)), 32'($urandom_range(4000)));
      endcase
      for (int n = 0; n < 200; n++) begin
        // Long output stall while beats keep coming, so the input backs up.
        if (blk == 6 && n == 20) hold_req <= hold_req + 1;
        // Let everything drain in the middle of a stream.
        if (blk == 7 && n == 100) wait_results();
        send_random_item();
      end
    end
    wait_results();

    if (fail_count == 0 && commands_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #(3_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
